/* rtl/core/jqrp_pkg.sv */
// Shared types and constants of the job queue: sizes, action and status codes,
// the job entry record and the per-cell shift command. No dependencies.
package jqrp_pkg;

  localparam int DEPTH       = 16;
  localparam int ID_BITS     = 16;
  localparam int PAGE_BITS   = 16;
  localparam int BYTE_BITS   = 10;
  localparam int ACT_BITS    = 3;
  localparam int STAT_BITS   = 3;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);

  typedef enum logic [ACT_BITS-1:0] {
    ACT_ENQ  = 3'd0,
    ACT_DEQ  = 3'd1,
    ACT_REM  = 3'd2,
    ACT_PRO  = 3'd3,
    ACT_LIST = 3'd4
  } act_e;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_ATHEAD   = 3'd4,
    ST_TOOFEW   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LIST
  } state_e;

  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic [PAGE_BITS-1:0] pages;
    logic [BYTE_BITS-1:0] bytes;
  } entry_t;

endpackage

/* rtl/core/jqrp_cell.sv */
// One queue slot of the cell row: holds a job and compares its id.
// Depends on jqrp_pkg.
module jqrp_cell (
  input  logic                         clk_i,
  input  jqrp_pkg::cell_op_e           op_i,
  input  jqrp_pkg::entry_t             left_i,
  input  jqrp_pkg::entry_t             right_i,
  input  jqrp_pkg::entry_t             load_i,
  input  logic [jqrp_pkg::ID_BITS-1:0] target_i,
  output jqrp_pkg::entry_t             entry_o,
  output logic                         match_o
);

  jqrp_pkg::entry_t entry_q, entry_d;

  always_comb begin
    case (op_i)
      jqrp_pkg::CELL_FROM_LEFT:  entry_d = left_i;
      jqrp_pkg::CELL_FROM_RIGHT: entry_d = right_i;
      jqrp_pkg::CELL_LOAD:       entry_d = load_i;
      default:                   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = (entry_q.id == target_i);

endmodule

/* rtl/core/jqrp_ctrl.sv */
// Queue controller: request capture, execute/list sequencer, entry count, id
// counter, per-cell shift commands and the result register. Depends on jqrp_pkg.
module jqrp_ctrl (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [jqrp_pkg::ACT_BITS-1:0]    action_i,
  input  logic [jqrp_pkg::ID_BITS-1:0]     target_id_i,
  input  logic [jqrp_pkg::PAGE_BITS-1:0]   page_count_i,
  input  logic [jqrp_pkg::BYTE_BITS-1:0]   byte_size_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [jqrp_pkg::STAT_BITS-1:0]   status_o,
  output logic [jqrp_pkg::ID_BITS-1:0]     job_id_o,
  output logic [jqrp_pkg::PAGE_BITS-1:0]   job_pages_o,
  output logic [jqrp_pkg::BYTE_BITS-1:0]   job_bytes_o,
  output logic                             last_o,
  output logic [jqrp_pkg::CNT_W-1:0]       occupancy_o,
  input  jqrp_pkg::entry_t                 cell_entry_i [jqrp_pkg::DEPTH],
  input  logic [jqrp_pkg::DEPTH-1:0]       cell_match_i,
  output jqrp_pkg::cell_op_e               cell_op_o [jqrp_pkg::DEPTH],
  output jqrp_pkg::entry_t                 load_o,
  output logic [jqrp_pkg::ID_BITS-1:0]     target_o
);

  localparam int D = jqrp_pkg::DEPTH;
  localparam int CW = jqrp_pkg::CNT_W;
  localparam int IW = jqrp_pkg::IDX_W;

  jqrp_pkg::state_e                 state_q, state_d;
  logic [jqrp_pkg::ACT_BITS-1:0]    act_q, act_d;
  logic [jqrp_pkg::ID_BITS-1:0]     target_q, target_d;
  logic [jqrp_pkg::PAGE_BITS-1:0]   pages_q, pages_d;
  logic [jqrp_pkg::BYTE_BITS-1:0]   bytes_q, bytes_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [jqrp_pkg::ID_BITS-1:0]     next_id_q, next_id_d;
  logic [IW-1:0]                    list_idx_q, list_idx_d;

  logic                             out_valid_q, out_valid_d;
  jqrp_pkg::status_e                out_status_q, out_status_d;
  jqrp_pkg::entry_t                 out_entry_q, out_entry_d;
  logic                             out_last_q, out_last_d;
  logic [CW-1:0]                    out_occ_q, out_occ_d;

  logic [D-1:0]     valid_vec;
  logic [D-1:0]     hit_raw;
  logic [D-1:0]     first_hit;
  logic [D-1:0]     pick;
  logic [D-1:0]     at_or_after;
  logic [CW-1:0]    cnt_m1;
  logic             slot_free;
  jqrp_pkg::entry_t picked;

  // Slot occupancy and first-match search over the cell row; dequeue always picks the head
  always_comb begin
    for (int i = 0; i < D; i++) begin
      valid_vec[i] = (CW'(i) < count_q);
    end
    hit_raw   = cell_match_i & valid_vec;
    first_hit = hit_raw & (~hit_raw + D'(1));
    pick      = (jqrp_pkg::act_e'(act_q) == jqrp_pkg::ACT_DEQ) ? D'(1) : first_hit;
    at_or_after = ~(pick - D'(1));
    picked    = '0;
    for (int i = 0; i < D; i++) begin
      if (pick[i]) begin
        picked = picked | cell_entry_i[i];
      end
    end
  end

  assign cnt_m1    = count_q - CW'(1);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != jqrp_pkg::S_IDLE);
  assign target_o  = target_q;

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    target_d     = target_q;
    pages_d      = pages_q;
    bytes_d      = bytes_q;
    count_d      = count_q;
    next_id_d    = next_id_q;
    list_idx_d   = list_idx_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_entry_d  = out_entry_q;
    out_last_d   = out_last_q;
    out_occ_d    = out_occ_q;
    load_o       = '0;
    for (int i = 0; i < D; i++) begin
      cell_op_o[i] = jqrp_pkg::CELL_HOLD;
    end

    case (state_q)
      jqrp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          act_d    = action_i;
          target_d = target_id_i;
          pages_d  = page_count_i;
          bytes_d  = byte_size_i;
          state_d  = jqrp_pkg::S_EXEC;
        end
      end

      jqrp_pkg::S_EXEC: begin
        if (slot_free) begin
          state_d      = jqrp_pkg::S_IDLE;
          out_valid_d  = 1'b1;
          out_last_d   = 1'b1;
          out_entry_d  = '0;
          out_status_d = jqrp_pkg::ST_OK;
          case (jqrp_pkg::act_e'(act_q))
            jqrp_pkg::ACT_ENQ: begin
              if (count_q == CW'(D)) begin
                out_status_d = jqrp_pkg::ST_FULL;
              end else begin
                load_o.id    = next_id_q;
                load_o.pages = pages_q;
                load_o.bytes = bytes_q;
                cell_op_o[count_q[IW-1:0]] = jqrp_pkg::CELL_LOAD;
                count_d     = count_q + CW'(1);
                next_id_d   = next_id_q + jqrp_pkg::ID_BITS'(1);
                out_entry_d = load_o;
              end
            end
            jqrp_pkg::ACT_DEQ, jqrp_pkg::ACT_REM: begin
              if (count_q == '0) begin
                out_status_d = jqrp_pkg::ST_EMPTY;
              end else if (pick == '0) begin
                out_status_d = jqrp_pkg::ST_NOTFOUND;
              end else begin
                // close the gap: everything behind the removed job moves up
                for (int i = 0; i < D; i++) begin
                  if (at_or_after[i] && (CW'(i) < cnt_m1)) begin
                    cell_op_o[i] = jqrp_pkg::CELL_FROM_RIGHT;
                  end
                end
                count_d     = cnt_m1;
                out_entry_d = picked;
              end
            end
            jqrp_pkg::ACT_PRO: begin
              if (count_q < CW'(2)) begin
                out_status_d = jqrp_pkg::ST_TOOFEW;
              end else if (pick == '0) begin
                out_status_d = jqrp_pkg::ST_NOTFOUND;
              end else if (pick[0]) begin
                out_status_d = jqrp_pkg::ST_ATHEAD;
                out_entry_d  = picked;
              end else begin
                // head takes the found job, jobs ahead of it slide back one
                load_o       = picked;
                cell_op_o[0] = jqrp_pkg::CELL_LOAD;
                for (int i = 1; i < D; i++) begin
                  if (!at_or_after[i] || pick[i]) begin
                    cell_op_o[i] = jqrp_pkg::CELL_FROM_LEFT;
                  end
                end
                out_entry_d = picked;
              end
            end
            jqrp_pkg::ACT_LIST: begin
              if (count_q == '0) begin
                out_status_d = jqrp_pkg::ST_EMPTY;
              end else begin
                out_valid_d = out_valid_q && out_stall_i;
                list_idx_d  = '0;
                state_d     = jqrp_pkg::S_LIST;
              end
            end
            default: begin
              // unused action codes: no result, no change
              out_valid_d = out_valid_q && out_stall_i;
            end
          endcase
          out_occ_d = count_d;
        end
      end

      jqrp_pkg::S_LIST: begin
        if (slot_free) begin
          // emit the head, then rotate the row: head wraps to the tail slot
          out_valid_d  = 1'b1;
          out_status_d = jqrp_pkg::ST_OK;
          out_entry_d  = cell_entry_i[0];
          out_occ_d    = count_q;
          out_last_d   = (list_idx_q == cnt_m1[IW-1:0]);
          load_o       = cell_entry_i[0];
          for (int i = 0; i < D; i++) begin
            if (CW'(i) < cnt_m1) begin
              cell_op_o[i] = jqrp_pkg::CELL_FROM_RIGHT;
            end
          end
          cell_op_o[cnt_m1[IW-1:0]] = jqrp_pkg::CELL_LOAD;
          list_idx_d = list_idx_q + IW'(1);
          if (out_last_d) begin
            state_d = jqrp_pkg::S_IDLE;
          end
        end
      end

      default: begin
        state_d = jqrp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jqrp_pkg::S_IDLE;
      count_q     <= '0;
      next_id_q   <= '0;
      list_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      next_id_q   <= next_id_d;
      list_idx_q  <= list_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    target_q     <= target_d;
    pages_q      <= pages_d;
    bytes_q      <= bytes_d;
    out_status_q <= out_status_d;
    out_entry_q  <= out_entry_d;
    out_last_q   <= out_last_d;
    out_occ_q    <= out_occ_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign job_id_o    = out_entry_q.id;
  assign job_pages_o = out_entry_q.pages;
  assign job_bytes_o = out_entry_q.bytes;
  assign last_o      = out_last_q;
  assign occupancy_o = out_occ_q;

endmodule

/* rtl/core/job_queue_with_remove_and_promote_top.sv */
// Top level of the job queue: a row of jqrp_cell slots, head in cell 0, run by
// jqrp_ctrl. Depends on jqrp_pkg, jqrp_cell and jqrp_ctrl.
//
// Ordered job queue of up to 16 jobs (id, page count, byte size). One request
// is handled at a time: it is captured into registers and executed in the
// execute state once the result register is free (held by out_stall_i). In
// the execute cycle every cell compares its id with the target in parallel,
// the first match nearest the head is picked (dequeue takes the head), and
// the row shifts by one slot in that same cycle. A list request streams one
// result per cycle while out_stall_i is low, from head to tail by rotating
// the row through cell 0; the last result carries last=1. Error results
// (empty, not found, full, too few) carry zero job fields; "already at head"
// reports the head job. Ids come from a 16-bit wrapping counter that only
// advances on a successful enqueue. Action codes 5 to 7 produce no result. A
// result waits in an output register, so a new request is accepted while the
// previous result has not been taken.
module job_queue_with_remove_and_promote_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [jqrp_pkg::ACT_BITS-1:0]    action_i,
  input  logic [jqrp_pkg::ID_BITS-1:0]     target_id_i,
  input  logic [jqrp_pkg::PAGE_BITS-1:0]   page_count_i,
  input  logic [jqrp_pkg::BYTE_BITS-1:0]   byte_size_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [jqrp_pkg::STAT_BITS-1:0]   status_o,
  output logic [jqrp_pkg::ID_BITS-1:0]     job_id_o,
  output logic [jqrp_pkg::PAGE_BITS-1:0]   job_pages_o,
  output logic [jqrp_pkg::BYTE_BITS-1:0]   job_bytes_o,
  output logic                             last_o,
  output logic [jqrp_pkg::CNT_W-1:0]       occupancy_o
);

  localparam int D = jqrp_pkg::DEPTH;

  jqrp_pkg::entry_t              cell_entry [D];
  jqrp_pkg::cell_op_e            cell_op    [D];
  logic [D-1:0]                  cell_match;
  jqrp_pkg::entry_t              load_bus;
  logic [jqrp_pkg::ID_BITS-1:0]  target;

  jqrp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .target_id_i  (target_id_i),
    .page_count_i (page_count_i),
    .byte_size_i  (byte_size_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .job_id_o     (job_id_o),
    .job_pages_o  (job_pages_o),
    .job_bytes_o  (job_bytes_o),
    .last_o       (last_o),
    .occupancy_o  (occupancy_o),
    .cell_entry_i (cell_entry),
    .cell_match_i (cell_match),
    .cell_op_o    (cell_op),
    .load_o       (load_bus),
    .target_o     (target)
  );

  // Cell row: each slot takes from its left neighbor (toward head), its right
  // neighbor (toward tail) or the shared load bus. Ends see an idle zero entry.
  for (genvar g = 0; g < D; g++) begin : g_cell
    jqrp_pkg::entry_t left_nb, right_nb;

    if (g == 0) begin : g_head
      assign left_nb = '0;
    end else begin : g_mid_l
      assign left_nb = cell_entry[g-1];
    end

    if (g == D - 1) begin : g_tail
      assign right_nb = '0;
    end else begin : g_mid_r
      assign right_nb = cell_entry[g+1];
    end

    jqrp_cell u_cell (
      .clk_i    (clk_i),
      .op_i     (cell_op[g]),
      .left_i   (left_nb),
      .right_i  (right_nb),
      .load_i   (load_bus),
      .target_i (target),
      .entry_o  (cell_entry[g]),
      .match_o  (cell_match[g])
    );
  end

  // A request keeps the controller busy for at least the following cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted back to back");

  // Occupancy never exceeds the number of cells
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (occupancy_o <= jqrp_pkg::CNT_W'(D)))
    else $error("occupancy above depth");

  // Error results are single, final and carry no job
  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != jqrp_pkg::ST_OK && status_o != jqrp_pkg::ST_ATHEAD)
      |-> (last_o && job_id_o == '0 && job_pages_o == '0 && job_bytes_o == '0))
    else $error("error result with job fields or without last");

  // An error result never appears in the middle of a list stream
  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != jqrp_pkg::ST_OK) |-> !(in_stall_o && !out_stall_i
      && $past(out_valid_o) && $past(status_o) == jqrp_pkg::ST_OK && !$past(last_o)))
    else $error("error result inside a list stream");

endmodule
